### rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, operation kinds, status codes and access modes of the record
// slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  // Field widths of the request and response transfers
  localparam int KIND_W   = 3;
  localparam int ID_W     = 11;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  // Default sizing
  localparam int SLOT_COUNT_DEF  = 1024;
  localparam int RECORD_BITS_DEF = 32;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEEK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd5;

  // Response status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_READ  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_WRITE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_END      = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd6;

  // Access modes
  localparam logic [MODE_W-1:0] MODE_RD_ONLY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_ONLY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RD_WR   = 2'd2;

endpackage

`default_nettype wire

### rtl/rss_req_if.sv
// ----------------------------------------------------------------------------
// rss_req_if
// Request channel: one operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_req_if;
  logic                        valid;
  logic                        ready;
  logic [rss_pkg::KIND_W-1:0]  kind;
  logic [rss_pkg::ID_W-1:0]    slot_id;
  logic [rss_pkg::DATA_W-1:0]  record_data;

  modport source (output valid, kind, slot_id, record_data, input ready);
  modport sink   (input valid, kind, slot_id, record_data, output ready);
endinterface

`default_nettype wire

### rtl/rss_rsp_if.sv
// ----------------------------------------------------------------------------
// rss_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rss_pkg::STATUS_W-1:0]  status;
  logic [rss_pkg::ID_W-1:0]      result_id;
  logic [rss_pkg::DATA_W-1:0]    result_data;
  logic                          is_deleted;

  modport source (output valid, status, result_id, result_data, is_deleted, input ready);
  modport sink   (input valid, status, result_id, result_data, is_deleted, output ready);
endinterface

`default_nettype wire

### rtl/rss_ram.sv
// ----------------------------------------------------------------------------
// rss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/record_slot_store_with_free_list.sv
// ----------------------------------------------------------------------------
// record_slot_store_with_free_list
// Fixed-size record store addressed by slot id from 1 upward, with a chain of
// deleted slots threaded through a link field and reused on the next write.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake     | carries
//  --------+-----------+---------------+------------------------------------
//  req     | in        | valid / ready | kind, slot_id, record_data
//  rsp     | out       | valid / ready | status, result_id, result_data,
//          |           |               | is_deleted
//  cfg     | in        | cfg_we only   | access_mode (cfg_wdata)
//
//  Every request is accepted in idle, which issues the memory read; exec then
//  checks the entry, writes it back if the kind modifies it and loads the response.
//  Read next stays in exec for every deleted slot it steps over, since each
//  slot visited costs one read of the single memory read port.
//  Reset sets the fresh id and scan pointer to 1, empties the chain and selects
//  read-write mode; the memory needs no clearing pass, as only slots already
//  handed out are read. A response waiting on rsp holds off the next request
//  until it transfers.
`default_nettype none

module record_slot_store_with_free_list #(
  parameter int SLOT_COUNT  = rss_pkg::SLOT_COUNT_DEF,
  parameter int RECORD_BITS = rss_pkg::RECORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [rss_pkg::MODE_W-1:0]  cfg_wdata,
  rss_req_if.sink                          req,
  rss_rsp_if.source                        rsp
);

  // Counter width holds ids up to SLOT_COUNT + 1 (one past the last slot)
  localparam int CNT_W  = $clog2(SLOT_COUNT + 2);
  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CMP_W  = (CNT_W > rss_pkg::ID_W) ? CNT_W : rss_pkg::ID_W;
  // Memory word: {deleted mark, chain link, record}
  localparam int WORD_W = 1 + CNT_W + RECORD_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                          state, state_next;
  logic [rss_pkg::KIND_W-1:0]    op_kind;
  logic [rss_pkg::ID_W-1:0]      op_id;
  logic [RECORD_BITS-1:0]        op_data;
  logic [CNT_W-1:0]              fresh_id, fresh_id_next;
  logic [CNT_W-1:0]              free_head, free_head_next;
  logic [CNT_W-1:0]              scan_ptr, scan_ptr_next;
  logic [rss_pkg::MODE_W-1:0]    access_mode;

  logic                          res_valid;
  logic [rss_pkg::STATUS_W-1:0]  res_status, res_status_next;
  logic [rss_pkg::ID_W-1:0]      res_id, res_id_next;
  logic [rss_pkg::DATA_W-1:0]    res_data, res_data_next;
  logic                          res_del, res_del_next;
  logic                          res_load;

  logic                          accept;
  logic                          ram_we, ram_re;
  logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
  logic [WORD_W-1:0]             ram_wdata, ram_rdata;
  logic [CNT_W-1:0]              rd_id;

  logic                          rd_mark;
  logic [CNT_W-1:0]              rd_link;
  logic [RECORD_BITS-1:0]        rd_rec;
  logic [CMP_W-1:0]              op_id_cmp;
  logic                          id_ok, may_write, may_read;

  // Accept only between operations, with the response register free or
  // being drained in the same cycle
  assign req.ready = (state == S_IDLE) && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.result_id   = res_id;
  assign rsp.result_data = res_data;
  assign rsp.is_deleted  = res_del;

  assign {rd_mark, rd_link, rd_rec} = ram_rdata;

  assign op_id_cmp = CMP_W'(op_id);
  assign id_ok     = (op_id_cmp != '0) && (op_id_cmp < CMP_W'(fresh_id));
  assign may_write = (access_mode != rss_pkg::MODE_RD_ONLY);
  assign may_read  = (access_mode != rss_pkg::MODE_WR_ONLY);

  rss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read side, write back and response for the current operation
  always_comb begin
    state_next      = state;
    fresh_id_next   = fresh_id;
    free_head_next  = free_head;
    scan_ptr_next   = scan_ptr;
    res_load        = 1'b0;
    res_status_next = rss_pkg::STAT_OK;
    res_id_next     = '0;
    res_data_next   = '0;
    res_del_next    = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ADDR_W'(op_id_cmp - 1'b1);
    ram_wdata       = {rd_mark, rd_link, op_data};
    ram_re          = 1'b0;
    rd_id           = CNT_W'(req.slot_id);

    if (state == S_IDLE) begin
      // Fetch the entry the operation will look at
      ram_re = accept;
      if (req.kind == rss_pkg::KIND_WRITE) begin
        rd_id = free_head;
      end else if (req.kind == rss_pkg::KIND_NEXT) begin
        rd_id = scan_ptr;
      end
      if (accept) begin
        state_next = S_EXEC;
      end
    end else begin
      // A skipped slot fetches the one after the pointer
      rd_id      = scan_ptr + 1'b1;
      res_load   = 1'b1;
      state_next = S_IDLE;
      unique case (op_kind)
        rss_pkg::KIND_WRITE: begin
          if (!may_write) begin
            res_status_next = rss_pkg::STAT_NO_WRITE;
          end else if (free_head != '0) begin
            // Pop the chain head; its link was fetched at accept
            ram_we         = 1'b1;
            ram_waddr      = ADDR_W'(free_head - 1'b1);
            ram_wdata      = {1'b0, rd_link, op_data};
            free_head_next = rd_link;
            res_id_next    = rss_pkg::ID_W'(free_head);
          end else if (fresh_id <= CNT_W'(SLOT_COUNT)) begin
            ram_we        = 1'b1;
            ram_waddr     = ADDR_W'(fresh_id - 1'b1);
            ram_wdata     = {1'b0, rd_link, op_data};
            fresh_id_next = fresh_id + 1'b1;
            res_id_next   = rss_pkg::ID_W'(fresh_id);
          end else begin
            res_status_next = rss_pkg::STAT_FULL;
          end
        end
        rss_pkg::KIND_UPDATE: begin
          if (!may_write) begin
            res_status_next = rss_pkg::STAT_NO_WRITE;
          end else if (!id_ok) begin
            res_status_next = rss_pkg::STAT_RANGE;
          end else if (rd_mark) begin
            res_status_next = rss_pkg::STAT_DELETED;
          end else begin
            ram_we      = 1'b1;
            ram_wdata   = {1'b0, rd_link, op_data};
            res_id_next = op_id;
          end
        end
        rss_pkg::KIND_DELETE: begin
          if (!may_write) begin
            res_status_next = rss_pkg::STAT_NO_WRITE;
          end else if (!id_ok) begin
            res_status_next = rss_pkg::STAT_RANGE;
          end else if (rd_mark) begin
            res_status_next = rss_pkg::STAT_DELETED;
          end else begin
            // Push onto the chain, keeping the record contents
            ram_we         = 1'b1;
            ram_wdata      = {1'b1, free_head, rd_rec};
            free_head_next = CNT_W'(op_id_cmp);
            res_id_next    = op_id;
          end
        end
        rss_pkg::KIND_READ: begin
          if (!id_ok) begin
            res_status_next = rss_pkg::STAT_RANGE;
          end else if (!may_read) begin
            res_status_next = rss_pkg::STAT_NO_READ;
          end else begin
            res_id_next   = op_id;
            res_data_next = rss_pkg::DATA_W'(rd_rec);
            res_del_next  = rd_mark;
          end
        end
        rss_pkg::KIND_SEEK: begin
          if (!id_ok) begin
            res_status_next = rss_pkg::STAT_RANGE;
          end else begin
            scan_ptr_next = CNT_W'(op_id_cmp);
            res_id_next   = op_id;
          end
        end
        rss_pkg::KIND_NEXT: begin
          if (scan_ptr < fresh_id) begin
            scan_ptr_next = scan_ptr + 1'b1;
            if (!rd_mark) begin
              res_id_next   = rss_pkg::ID_W'(scan_ptr);
              res_data_next = rss_pkg::DATA_W'(rd_rec);
            end else begin
              // Skip the deleted slot: fetch the following one and stay
              ram_re     = 1'b1;
              res_load   = 1'b0;
              state_next = S_EXEC;
            end
          end else begin
            res_status_next = rss_pkg::STAT_END;
          end
        end
        default: begin
          // Unused kinds: plain ok with empty fields
        end
      endcase
    end

    ram_raddr = ADDR_W'(rd_id - 1'b1);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fresh_id    <= CNT_W'(1);
      free_head   <= '0;
      scan_ptr    <= CNT_W'(1);
      access_mode <= rss_pkg::MODE_RD_WR;
      res_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      fresh_id  <= fresh_id_next;
      free_head <= free_head_next;
      scan_ptr  <= scan_ptr_next;
      if (cfg_we) begin
        access_mode <= cfg_wdata;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload: hold the accepted request and the pending response
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= req.kind;
      op_id   <= req.slot_id;
      op_data <= RECORD_BITS'(req.record_data);
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_id     <= res_id_next;
      res_data   <= res_data_next;
      res_del    <= res_del_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks of the record slot store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic [rss_pkg::STATUS_W-1:0]  rsp_status,
  input wire logic [rss_pkg::ID_W-1:0]      rsp_result_id,
  input wire logic [rss_pkg::DATA_W-1:0]    rsp_result_data,
  input wire logic                          rsp_is_deleted
);

  // One operation at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous operation in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status <= rss_pkg::STAT_FULL)
    else $error("undefined status code");

  // Errors and scan end carry empty fields
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != rss_pkg::STAT_OK |->
      rsp_result_id == '0 && rsp_result_data == '0 && !rsp_is_deleted)
    else $error("error response with nonzero fields");

  a_deleted_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_deleted |->
      rsp_status == rss_pkg::STAT_OK && rsp_result_id != '0)
    else $error("deleted mark on a response that read no slot");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind record_slot_store_with_free_list rss_checker u_rss_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_status      (rsp.status),
  .rsp_result_id   (rsp.result_id),
  .rsp_result_data (rsp.result_data),
  .rsp_is_deleted  (rsp.is_deleted)
);

`default_nettype wire
